FILE: hw/rtl/mpoc_pkg.sv
// ----------------------------------------------------------------------------
// Motor phase order check package
// Shared types, register indexes and reset constants for the phase order
// check block.
// ----------------------------------------------------------------------------
package mpoc_pkg;

  localparam int POS_BITS_DEF = 16;

  // Evaluations without rotation before the check gives up.
  localparam logic [7:0]  TRY_LIMIT          = 8'd200;

  localparam logic [15:0] SETTLE_TICKS_RESET = 16'd10;
  localparam logic [15:0] POSITION_MAX_RESET = 16'd3999;
  localparam logic [14:0] DEAD_ZONE_RESET    = 15'd10;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_CHECK_ENABLE     = 3'd0,
    CFG_SETTLE_TICKS     = 3'd1,
    CFG_POSITION_MAX     = 3'd2,
    CFG_DEAD_ZONE        = 3'd3,
    CFG_INVERT_DIRECTION = 3'd4
  } cfg_idx_t;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic        check_enable;
    logic [15:0] settle_ticks;
    logic [15:0] position_max;
    logic [14:0] dead_zone;
    logic        invert_direction;
  } cfg_t;

  typedef struct packed {
    logic              motor_stopped;
    logic [15:0]       position;
    logic              gap_busy;
    logic signed [1:0] requested_dir;
    logic              clear_fault;
  } item_t;

  // Run state apart from the captured start position, whose width is set
  // by the position parameter.
  typedef struct packed {
    logic [15:0]       settle_count;
    logic [7:0]        try_count;
    logic              done_flag;
    logic              fault_flag;
    logic signed [1:0] direction_value;
  } run_state_t;

endpackage

FILE: hw/rtl/mpoc_eval.sv
// ----------------------------------------------------------------------------
// Phase order check update
// Combinational next-state logic for one tick: capture, settle count and
// rotation classification with wrap at the encoder modulus.
// ----------------------------------------------------------------------------
module mpoc_eval
  import mpoc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  cfg_t                cfg,
  input  item_t               item,
  input  run_state_t          st,
  input  logic [POS_BITS-1:0] start_pos,
  output run_state_t          st_nxt,
  output logic [POS_BITS-1:0] start_pos_nxt
);

  // Wide enough for a position difference plus or minus one modulus.
  localparam int DW = ((POS_BITS > 16) ? POS_BITS : 16) + 3;

  logic [POS_BITS-1:0] pos_w;
  logic signed [DW-1:0] pos_s, start_s, modulus_s, half_s, zone_s;
  logic signed [DW-1:0] d0, d1, d2;
  logic signed [1:0]    dir;
  logic [7:0]           try_inc;

  assign pos_w = POS_BITS'(item.position);

  // Signed position change, folded once each way around the half modulus.
  always_comb begin
    pos_s     = DW'(pos_w);
    start_s   = DW'(start_pos);
    modulus_s = DW'(cfg.position_max) + DW'(1);
    half_s    = modulus_s >>> 1;
    zone_s    = DW'(cfg.dead_zone);
    d0        = pos_s - start_s;
    d1        = (d0 > half_s) ? (d0 - modulus_s) : d0;
    d2        = (d1 < -half_s) ? (d1 + modulus_s) : d1;
  end

  // Reverse test wins over forward, so a zero change with no dead zone reads
  // as reverse.
  always_comb begin
    dir = 2'sd0;
    if (d2 >= zone_s) begin
      dir = 2'sd1;
    end
    if (d2 <= -zone_s) begin
      dir = -2'sd1;
    end
    if (cfg.invert_direction) begin
      dir = -dir;
    end
  end

  assign try_inc = st.try_count + 8'd1;

  always_comb begin
    st_nxt        = st;
    start_pos_nxt = start_pos;
    // A fault found on the same tick as a clear stays set.
    if (item.clear_fault) begin
      st_nxt.fault_flag = 1'b0;
    end
    if (!cfg.check_enable || item.motor_stopped) begin
      st_nxt.done_flag    = 1'b0;
      st_nxt.settle_count = '0;
      st_nxt.try_count    = '0;
      start_pos_nxt       = pos_w;
    end else if (st.settle_count < cfg.settle_ticks) begin
      st_nxt.settle_count = st.settle_count + 16'd1;
    end else if (!st.done_flag && !item.gap_busy) begin
      st_nxt.direction_value = dir;
      if ((dir != 2'sd0) && (dir != item.requested_dir)) begin
        st_nxt.fault_flag = 1'b1;
      end
      if ((try_inc >= TRY_LIMIT) || (dir != 2'sd0)) begin
        st_nxt.try_count = '0;
        st_nxt.done_flag = 1'b1;
      end else begin
        st_nxt.try_count = try_inc;
      end
    end
  end

endmodule

FILE: hw/rtl/motor_phase_order_check_core.sv
// ----------------------------------------------------------------------------
// Motor phase order check core
// Checks per tick that the motor turns in the commanded direction and keeps
// a sticky fault when the phase order is wrong.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake             Content
//  in_      slave      in_tvalid/in_tready   one tick: stop flag, position,
//                                            gap busy, requested dir, clear
//  out_     master     out_tvalid/out_tready one result per tick: direction,
//                                            fault, done
//  cfg_     write      cfg_wen               register index and write data
//
// Each tick passes through the input register, then the update logic writes
// the run state, which is also the result register. A new tick can be taken
// every cycle while the result side does not stall.
// Reset (rst_n low, synchronous) empties both stages, clears the run state
// and loads the register defaults.
// When the result is not taken, the input register still holds one tick, so
// the input side stalls only when both stages are full.
// ----------------------------------------------------------------------------
module motor_phase_order_check_core
  import mpoc_pkg::*;
#(
  parameter int POS_BITS = POS_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] motor_stopped, [16:1] position, [17] gap_busy,
  // [19:18] requested_dir, [20] clear_fault, [23:21] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [1:0] phase_dir, [2] phase_fault, [3] check_done, [7:4] zero
  output logic [OUT_DATA_W-1:0] out_tdata,

  input  logic                  cfg_wen,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // Configuration registers. Writes with an index beyond the list are
  // ignored.
  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.check_enable     <= 1'b1;
      cfg_r.settle_ticks     <= SETTLE_TICKS_RESET;
      cfg_r.position_max     <= POSITION_MAX_RESET;
      cfg_r.dead_zone        <= DEAD_ZONE_RESET;
      cfg_r.invert_direction <= 1'b0;
    end else if (cfg_wen) begin
      case (cfg_addr)
        CFG_CHECK_ENABLE:     cfg_r.check_enable     <= cfg_wdata[0];
        CFG_SETTLE_TICKS:     cfg_r.settle_ticks     <= cfg_wdata;
        CFG_POSITION_MAX:     cfg_r.position_max     <= cfg_wdata;
        CFG_DEAD_ZONE:        cfg_r.dead_zone        <= cfg_wdata[14:0];
        CFG_INVERT_DIRECTION: cfg_r.invert_direction <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Input register stage. The tick advances into the update logic when the
  // result register is empty or its result is being taken in this cycle.
  logic  s1_valid_r;
  item_t s1_item_r;
  logic  out_valid_r;
  logic  advance;

  assign advance   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.motor_stopped <= in_tdata[0];
      s1_item_r.position      <= in_tdata[16:1];
      s1_item_r.gap_busy      <= in_tdata[17];
      s1_item_r.requested_dir <= in_tdata[19:18];
      s1_item_r.clear_fault   <= in_tdata[20];
    end
  end

  // Run state. It changes only when a tick advances, so the direction,
  // fault and done fields double as the held result payload.
  run_state_t          st_r, st_nxt;
  logic [POS_BITS-1:0] start_pos_r, start_pos_nxt;

  mpoc_eval #(
    .POS_BITS (POS_BITS)
  ) u_eval (
    .cfg           (cfg_r),
    .item          (s1_item_r),
    .st            (st_r),
    .start_pos     (start_pos_r),
    .st_nxt        (st_nxt),
    .start_pos_nxt (start_pos_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= '0;
      start_pos_r <= '0;
    end else if (advance) begin
      st_r        <= st_nxt;
      start_pos_r <= start_pos_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {4'b0000, st_r.done_flag, st_r.fault_flag, st_r.direction_value};

  // A finished check always leaves the try counter cleared.
  a_done_clears_tries: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.done_flag |-> (st_r.try_count == 8'd0))
    else $error("try counter not cleared while check is done");

  // The try counter never reaches its limit.
  a_try_below_limit: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.try_count < TRY_LIMIT)
    else $error("try counter reached its limit");

  // Classification only ever yields forward, reverse or none.
  a_dir_legal: assert property (@(posedge clk) disable iff (!rst_n)
    st_r.direction_value != 2'b10)
    else $error("detected direction out of range");

  // The fault can only rise when a tick was processed.
  a_fault_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(st_r.fault_flag) |-> $past(advance))
    else $error("fault set without a processed tick");

endmodule

FILE: dv/testbench.sv
// ----------------------------------------------------------------------------
// Motor phase order check testbench
// Drives ticks into the phase order check core and compares every result
// transfer with a cycle-free model of the run state kept in this bench. A
// short table of directed ticks comes first, then random runs across many
// register settings, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module testbench
  import mpoc_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  // The run ends with a failure if it is still going after this many cycles.
  localparam int LIMIT_CYCLES = 400000;
  localparam int PHASES       = 15;
  localparam int MAX_PRINTS   = 50;

  // One result transfer: last direction, sticky fault and done flag.
  typedef struct packed {
    logic signed [1:0] dir;
    logic              fault;
    logic              done;
  } verdict_t;

  // One row of the directed table: either a register write or a tick, and
  // for a few ticks a result that is typed in by hand.
  typedef struct {
    bit          is_cfg;
    cfg_idx_t    reg_idx;
    logic [15:0] reg_val;
    item_t       tick;
    bit          typed;
    verdict_t    want;
  } row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_wen;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  motor_phase_order_check_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wen    (cfg_wen),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  // Bench copy of the register file, loaded with the reset defaults.
  cfg_t shadow_cfg = '{check_enable: 1'b1, settle_ticks: SETTLE_TICKS_RESET,
                       position_max: POSITION_MAX_RESET,
                       dead_zone: DEAD_ZONE_RESET, invert_direction: 1'b0};

  // Bench copy of the run state, all zero after reset.
  logic [15:0]       st_start  = '0;
  logic [15:0]       st_settle = '0;
  logic [7:0]        st_tries  = '0;
  logic              st_done   = 1'b0;
  logic              st_fault  = 1'b0;
  logic signed [1:0] st_dir    = '0;

  verdict_t expected_verdicts[$];
  int       mismatches = 0;
  int       cycles     = 0;
  bit       idling     = 1'b1;

  // Hand-typed result for the tick currently offered, if any.
  bit       want_typed = 1'b0;
  verdict_t want_fixed = '0;

  row_t     rows[$];

  // --------------------------------------------------------------------------
  // Clock and cycle limit.
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results still due", cycles,
               expected_verdicts.size());
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Prediction. One call per accepted tick, in transfer order. It follows the
  // block's update rules on the bench copies of state and registers and
  // returns what the result transfer for this tick must carry.
  // --------------------------------------------------------------------------
  function automatic verdict_t phase_order_step(item_t tk);
    int       modulus;
    int       half;
    int       delta;
    int       zone;
    int       req;
    int       rot;
    verdict_t v;
    // The clear comes first, so a fault found on this tick survives it.
    if (tk.clear_fault)
      st_fault = 1'b0;
    if (!shadow_cfg.check_enable || tk.motor_stopped) begin
      // Stopped or disabled: restart the run, keep direction and fault.
      st_done   = 1'b0;
      st_start  = tk.position;
      st_settle = '0;
      st_tries  = '0;
    end else if (st_settle < shadow_cfg.settle_ticks) begin
      st_settle = st_settle + 16'd1;
    end else if (!st_done && !tk.gap_busy) begin
      modulus = int'(shadow_cfg.position_max) + 1;
      half    = modulus / 2;
      delta   = int'(tk.position) - int'(st_start);
      zone    = int'(shadow_cfg.dead_zone);
      req     = tk.requested_dir;
      // Shortest way around the encoder circle, each correction once.
      if (delta > half)
        delta -= modulus;
      if (delta < -half)
        delta += modulus;
      rot = 0;
      if (delta >= zone)
        rot = 1;
      // Tested second, so with no dead zone a zero change reads as reverse.
      if (delta <= -zone)
        rot = -1;
      if (shadow_cfg.invert_direction)
        rot = -rot;
      st_dir = rot[1:0];
      if (rot != 0 && rot != req)
        st_fault = 1'b1;
      st_tries = st_tries + 8'd1;
      if (st_tries >= TRY_LIMIT || rot != 0) begin
        st_tries = '0;
        st_done  = 1'b1;
      end
    end
    v.dir   = st_dir;
    v.fault = st_fault;
    v.done  = st_done;
    return v;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    if (mismatches < MAX_PRINTS)
      $display("mismatch at cycle %0d: %s got %0d, expected %0d", cycles, what,
               got, want);
    mismatches++;
  endtask

  // --------------------------------------------------------------------------
  // Monitor. At each rising edge it records register writes, predicts each
  // accepted tick and checks each accepted result against the oldest
  // expectation. Inputs were changed at the falling edge, so they are stable.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    item_t    seen;
    verdict_t pred;
    verdict_t want;
    if (rst_n) begin
      if (cfg_wen) begin
        case (cfg_addr)
          CFG_CHECK_ENABLE:     shadow_cfg.check_enable     = cfg_wdata[0];
          CFG_SETTLE_TICKS:     shadow_cfg.settle_ticks     = cfg_wdata[15:0];
          CFG_POSITION_MAX:     shadow_cfg.position_max     = cfg_wdata[15:0];
          CFG_DEAD_ZONE:        shadow_cfg.dead_zone        = cfg_wdata[14:0];
          CFG_INVERT_DIRECTION: shadow_cfg.invert_direction = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        seen.motor_stopped = in_tdata[0];
        seen.position      = in_tdata[16:1];
        seen.gap_busy      = in_tdata[17];
        seen.requested_dir = in_tdata[19:18];
        seen.clear_fault   = in_tdata[20];
        pred = phase_order_step(seen);
        expected_verdicts.push_back(want_typed ? want_fixed : pred);
      end
      if (out_tvalid && out_tready) begin
        if (expected_verdicts.size() == 0) begin
          report_mismatch("result transfer with nothing due, data", int'(out_tdata), 0);
        end else begin
          want = expected_verdicts.pop_front();
          if ($signed(out_tdata[1:0]) != want.dir)
            report_mismatch("phase_dir", int'($signed(out_tdata[1:0])), int'(want.dir));
          if (out_tdata[2] != want.fault)
            report_mismatch("phase_fault", int'(out_tdata[2]), int'(want.fault));
          if (out_tdata[3] != want.done)
            report_mismatch("check_done", int'(out_tdata[3]), int'(want.done));
          if (out_tdata[7:4] != 4'd0)
            report_mismatch("padding bits", int'(out_tdata[7:4]), 0);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result side back-pressure: random stall bursts while idling is on, ready
  // held high otherwise.
  // --------------------------------------------------------------------------
  initial begin
    int stall_left;
    stall_left = 0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
        out_tready = 1'b0;
      end else if (idling && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 14) - 1;
        out_tready = 1'b0;
      end else begin
        out_tready = 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers. All of them are entered and left at a falling edge.
  // --------------------------------------------------------------------------

  // Offer one tick and wait for its transfer. With idling on, a random gap
  // may go first. On return valid is still high with the old tick; the next
  // call replaces it in the same step, or a register write lowers it.
  task automatic push_tick(item_t tk, bit typed, verdict_t want);
    if (idling && $urandom_range(0, 3) == 0) begin
      in_tvalid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    want_typed = typed;
    want_fixed = want;
    in_tdata   = {3'b000, tk.clear_fault, tk.requested_dir, tk.gap_busy,
                  tk.position, tk.motor_stopped};
    in_tvalid  = 1'b1;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  // Wait until every result is back and the pipeline has drained, then
  // write one register.
  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    in_tvalid = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wen   = 1'b1;
    cfg_addr  = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_wen   = 1'b0;
  endtask

  function automatic void add_cfg(cfg_idx_t idx, logic [15:0] val);
    row_t r;
    r = '{reg_idx: CFG_CHECK_ENABLE, default: '0};
    r.is_cfg  = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    rows.push_back(r);
  endfunction

  function automatic void add_tick(bit stopped, logic [15:0] pos, bit gap, int req,
                                   bit clr, bit typed = 1'b0, int w_dir = 0,
                                   bit w_fault = 1'b0, bit w_done = 1'b0);
    row_t r;
    r = '{reg_idx: CFG_CHECK_ENABLE, default: '0};
    r.tick.motor_stopped = stopped;
    r.tick.position      = pos;
    r.tick.gap_busy      = gap;
    r.tick.requested_dir = req[1:0];
    r.tick.clear_fault   = clr;
    r.typed              = typed;
    r.want.dir           = w_dir[1:0];
    r.want.fault         = w_fault;
    r.want.done          = w_done;
    rows.push_back(r);
  endfunction

  // Random tick for the current run. Positions mostly sit within spread of
  // the captured start position, wrapped at the encoder modulus; noise_pct
  // percent of the ticks carry a fully random position.
  function automatic item_t random_tick(int stop_pm, int spread, int noise_pct);
    item_t tk;
    int    modulus;
    int    off;
    int    pos;
    int    req;
    int    pick;
    modulus = int'(shadow_cfg.position_max) + 1;
    tk.motor_stopped = ($urandom_range(0, 999) < stop_pm);
    tk.gap_busy      = ($urandom_range(0, 9) == 0);
    tk.clear_fault   = ($urandom_range(0, 11) == 0);
    pick = $urandom_range(0, 99);
    if (pick < 45)
      req = 1;
    else if (pick < 90)
      req = -1;
    else if (pick < 97)
      req = 0;
    else
      req = -2;
    tk.requested_dir = req[1:0];
    if ($urandom_range(0, 99) < noise_pct) begin
      tk.position = 16'($urandom);
    end else if (tk.motor_stopped) begin
      tk.position = 16'($urandom_range(0, modulus - 1));
    end else begin
      off = int'($urandom_range(0, 2 * spread)) - spread;
      pos = (int'(st_start) + off) % modulus;
      if (pos < 0)
        pos += modulus;
      tk.position = pos[15:0];
    end
    return tk;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int          len;
    int          stop_pm;
    int          spread;
    int          noise_pct;
    int          cap;
    bit          en;
    bit          inv;
    logic [15:0] settle;
    logic [15:0] pmax;
    logic [15:0] zone;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    cfg_wen   = 1'b0;
    cfg_addr  = CFG_CHECK_ENABLE;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n = 1'b1;

    // Directed table. Runs start with a stopped tick that captures the
    // start position; settle time is zero so evaluation starts at once.
    // Straight after reset everything reads zero.
    add_tick(1, 16'd0, 0, 0, 0, 1, 0, 0, 0);
    add_cfg(CFG_SETTLE_TICKS, 16'd0);
    add_tick(1, 16'd50, 0, 1, 0);
    add_tick(0, 16'd50, 1, 1, 0);       // gap timer busy blocks evaluation
    add_tick(0, 16'd65, 0, 1, 0);       // forward, as requested
    add_tick(0, 16'd0, 0, -1, 0);       // check already done, state held
    add_tick(1, 16'd3990, 0, -1, 0);
    add_tick(0, 16'd5, 0, 1, 0);        // wraps past zero: forward by 15
    add_tick(1, 16'd5, 0, 1, 0);
    add_tick(0, 16'd3990, 0, 1, 0);     // wraps back: reverse, fault
    add_tick(1, 16'd0, 0, 0, 1);        // stop keeps direction, clear fault
    // Position above the top count, used as given; direction -2 matches
    // nothing, so the forward rotation faults.
    add_tick(0, 16'hFFFF, 0, -2, 0, 1, 1, 1, 1);
    add_tick(1, 16'd100, 0, 1, 1);
    add_tick(0, 16'd300, 0, -1, 1);     // clear and new fault on one tick
    add_cfg(CFG_INVERT_DIRECTION, 16'd1);
    add_tick(1, 16'd100, 0, 1, 1);
    add_tick(0, 16'd300, 0, -1, 0);     // inverted: counts as reverse
    add_cfg(CFG_INVERT_DIRECTION, 16'd0);
    add_cfg(CFG_DEAD_ZONE, 16'd0);
    add_tick(1, 16'd7, 0, 1, 0);
    add_tick(0, 16'd7, 0, -1, 0);       // no dead zone: zero change is reverse
    add_cfg(CFG_POSITION_MAX, 16'hFFFF);
    add_cfg(CFG_DEAD_ZONE, 16'h7FFF);
    add_tick(1, 16'd0, 0, 1, 0);
    // Largest dead zone met exactly at the largest modulus.
    add_tick(0, 16'h7FFF, 0, 1, 1, 1, 1, 0, 1);
    add_tick(1, 16'hAAAA, 0, 1, 0);
    add_tick(0, 16'h5555, 0, 0, 0);
    add_cfg(CFG_CHECK_ENABLE, 16'd0);
    add_tick(0, 16'd1, 0, 1, 0);        // disabled acts as stopped
    add_cfg(CFG_CHECK_ENABLE, 16'd1);

    foreach (rows[i]) begin
      if (rows[i].is_cfg)
        write_reg(rows[i].reg_idx, rows[i].reg_val);
      else
        push_tick(rows[i].tick, rows[i].typed, rows[i].want);
    end

    // Random part: one register setting per phase, runs of random ticks in
    // each. A few phases pin the extremes; the last ones run without idling.
    for (int p = 0; p < PHASES; p++) begin
      en        = ($urandom_range(0, 9) != 0);
      inv       = 1'($urandom_range(0, 1));
      len       = $urandom_range(70, 130);
      stop_pm   = 30;
      noise_pct = 8;
      case ($urandom_range(0, 5))
        0:       settle = 16'd0;
        5:       settle = 16'($urandom_range(21, 300));
        default: settle = 16'($urandom_range(1, 20));
      endcase
      case ($urandom_range(0, 4))
        0:       pmax = 16'($urandom_range(1, 15));
        1:       pmax = POSITION_MAX_RESET;
        2:       pmax = 16'hFFFF;
        default: pmax = 16'($urandom_range(16, 65535));
      endcase
      cap = (int'(pmax) + 1) / 4;
      if (cap > 32767)
        cap = 32767;
      zone = ($urandom_range(0, 3) == 0) ? 16'd0 : 16'($urandom_range(0, cap));

      case (p)
        1: begin
          // Smallest modulus: the encoder only has two counts.
          pmax   = 16'd1;
          zone   = 16'($urandom_range(0, 1));
          settle = 16'd0;
          en     = 1'b1;
        end
        2: begin
          pmax   = 16'hFFFF;
          zone   = 16'h7FFF;
          settle = 16'($urandom_range(0, 3));
          en     = 1'b1;
        end
        3: begin
          // Longest settle time: no tick of this phase is evaluated.
          settle  = 16'hFFFF;
          en      = 1'b1;
          len     = 60;
          stop_pm = 0;
        end
        4: begin
          // Quiet runs that never leave the dead zone, so the check gives up after the try limit.
          settle    = 16'd0;
          pmax      = POSITION_MAX_RESET;
          zone      = 16'd1000;
          en        = 1'b1;
          len       = 450;
          stop_pm   = 1;
          noise_pct = 0;
        end
        5: begin
          en  = 1'b0;
          len = 50;
        end
        default: ;
      endcase
      spread = (p == 4) ? int'(zone) - 1 : int'(zone) + int'(zone) / 2 + 2;

      idling = (p < PHASES - 3) && ($urandom_range(0, 3) != 0);
      write_reg(CFG_CHECK_ENABLE, {15'd0, en});
      write_reg(CFG_SETTLE_TICKS, settle);
      write_reg(CFG_POSITION_MAX, pmax);
      write_reg(CFG_DEAD_ZONE, zone);
      write_reg(CFG_INVERT_DIRECTION, {15'd0, inv});

      repeat (len) push_tick(random_tick(stop_pm, spread, noise_pct), 1'b0, '0);
    end

    // Drain: every result must come back, then a few quiet cycles catch
    // any stray result transfer.
    in_tvalid = 1'b0;
    idling    = 1'b0;
    while (expected_verdicts.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
